// File: design/mdt_pkg.sv
// ----------------------------------------------------------------------------
// mdt_pkg: shared constants and types of the max drawdown tracker
// Default widths and the status bundle of the serial fraction divider.
// ----------------------------------------------------------------------------
package mdt_pkg;

   // default field widths
   localparam int VALUE_WIDTH_DEF   = 48;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int DATE_WIDTH_DEF    = 32;

   // divider status toward the control sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: design/mdt_if.sv
// ----------------------------------------------------------------------------
// mdt_if: handshake channels of the max drawdown tracker
// Sample channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface mdt_req_if #(
   parameter int VALUE_WIDTH = mdt_pkg::VALUE_WIDTH_DEF,
   parameter int DATE_WIDTH  = mdt_pkg::DATE_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;
   logic [DATE_WIDTH-1:0]         date_code;
   logic                          curve_start;

   modport source (output valid, output value, output date_code, output curve_start,
                   input ready);
   modport sink   (input valid, input value, input date_code, input curve_start,
                   output ready);
endinterface

interface mdt_rsp_if #(
   parameter int VALUE_WIDTH   = mdt_pkg::VALUE_WIDTH_DEF,
   parameter int FRACTION_BITS = mdt_pkg::FRACTION_BITS_DEF,
   parameter int DATE_WIDTH    = mdt_pkg::DATE_WIDTH_DEF
);
   logic                     valid;
   logic                     ready;
   logic [FRACTION_BITS:0]   drawdown_frac;
   logic [VALUE_WIDTH-2:0]   loss_amount;
   logic [DATE_WIDTH-1:0]    peak_code;
   logic [DATE_WIDTH-1:0]    trough_code;

   modport source (output valid, output drawdown_frac, output loss_amount,
                   output peak_code, output trough_code, input ready);
   modport sink   (input valid, input drawdown_frac, input loss_amount,
                   input peak_code, input trough_code, output ready);
endinterface

// File: design/mdt_serial_div.sv
// ----------------------------------------------------------------------------
// mdt_serial_div: restoring fraction divider, one quotient bit per cycle
// Forms floor(num / den * 2^FRACTION_BITS) for num < den; the quotient
// shifts in from the right, the partial remainder shifts left each step.
// ----------------------------------------------------------------------------
module mdt_serial_div #(
   parameter int VALUE_WIDTH   = mdt_pkg::VALUE_WIDTH_DEF,
   parameter int FRACTION_BITS = mdt_pkg::FRACTION_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [VALUE_WIDTH-1:0]     num,
   input  logic [VALUE_WIDTH-1:0]     den,
   output mdt_pkg::div_stat_type      status,
   output logic [FRACTION_BITS-1:0]   quot
);
   import mdt_pkg::*;

   localparam int CNT_W = $clog2(FRACTION_BITS);

   logic [VALUE_WIDTH-1:0]   rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0]   den_ff;
   logic [FRACTION_BITS-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [VALUE_WIDTH-1:0]   rem_shift;
   logic                     fits;

   // one restoring step: shift, trial compare, subtract on fit
   always_comb begin
      rem_shift = {rem_ff[VALUE_WIDTH-2:0], 1'b0};
      fits      = (rem_shift >= den_ff);
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         rem_in   = num;
         quot_in  = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? (rem_shift - den_ff) : rem_shift;
         quot_in  = {quot_ff[FRACTION_BITS-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(FRACTION_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath shift registers
   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      count_ff <= count_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quot        = quot_ff;

   // the sequencer never restarts a running division
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

   // partial remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < den_ff))
      else $error("partial remainder out of range");

   // done follows the last step of a running division
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("done without a running division");

endmodule

// File: design/max_drawdown_tracker.sv
// ----------------------------------------------------------------------------
// max_drawdown_tracker: running maximum drawdown of an equity curve
// Tracks the running peak and the largest fractional drawdown per sample.
// ----------------------------------------------------------------------------
// One sample is processed at a time. A sample that sets or raises the peak,
// starts a curve, or meets a non-positive peak goes from accept through
// ST_EVAL to ST_FINISH and its result; a sample at zero equity (a full
// drawdown) takes the same path. Any other sample runs the restoring divider
// in ST_DIV between the two, one quotient bit per cycle. The next sample is
// accepted as soon as the sequencer is idle, even while the last result beat
// still waits on rsp_chan; a finished result then holds until the slot frees.
// ----------------------------------------------------------------------------
module max_drawdown_tracker #(
   parameter int VALUE_WIDTH   = mdt_pkg::VALUE_WIDTH_DEF,
   parameter int FRACTION_BITS = mdt_pkg::FRACTION_BITS_DEF,
   parameter int DATE_WIDTH    = mdt_pkg::DATE_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   mdt_req_if.sink   req_chan,
   mdt_rsp_if.source rsp_chan
);
   import mdt_pkg::*;

   localparam logic [FRACTION_BITS:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EVAL   = 4'b0010,
      ST_DIV    = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // captured sample
   logic signed [VALUE_WIDTH-1:0] samp_value_ff;
   logic [DATE_WIDTH-1:0]         samp_date_ff;
   logic                          samp_start_ff;

   // tracking state
   logic signed [VALUE_WIDTH-1:0] peak_ff, peak_in;
   logic [DATE_WIDTH-1:0]         peak_date_ff, peak_date_in;
   logic [FRACTION_BITS:0]        best_frac_ff, best_frac_in;
   logic [VALUE_WIDTH-2:0]        best_amount_ff, best_amount_in;
   logic [DATE_WIDTH-1:0]         best_start_ff, best_start_in;
   logic [DATE_WIDTH-1:0]         best_end_ff, best_end_in;

   // candidate drawdown of the current sample
   logic                          cand_ff, cand_in;
   logic [FRACTION_BITS:0]        cand_frac_ff, cand_frac_in;
   logic [VALUE_WIDTH-2:0]        cand_amount_ff, cand_amount_in;

   // result slot
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [FRACTION_BITS:0]        rsp_frac_ff;
   logic [VALUE_WIDTH-2:0]        rsp_amount_ff;
   logic [DATE_WIDTH-1:0]         rsp_start_ff, rsp_end_ff;

   logic signed [VALUE_WIDTH-1:0] value_clamp;
   logic [VALUE_WIDTH-1:0]        diff;
   logic                          raises_peak;
   logic                          peak_pos;
   logic                          slot_free;
   logic                          div_start;
   div_stat_type                  div_stat;
   logic [FRACTION_BITS-1:0]      div_quot;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   // clamp later samples at zero and measure against the peak
   always_comb begin
      value_clamp = samp_value_ff[VALUE_WIDTH-1] ? '0 : samp_value_ff;
      raises_peak = (value_clamp > peak_ff);
      peak_pos    = !peak_ff[VALUE_WIDTH-1] && (peak_ff != '0);
      diff        = VALUE_WIDTH'(peak_ff - value_clamp);
   end

   // sequencer and state update
   always_comb begin
      state_in       = state_ff;
      peak_in        = peak_ff;
      peak_date_in   = peak_date_ff;
      best_frac_in   = best_frac_ff;
      best_amount_in = best_amount_ff;
      best_start_in  = best_start_ff;
      best_end_in    = best_end_ff;
      cand_in        = cand_ff;
      cand_frac_in   = cand_frac_ff;
      cand_amount_in = cand_amount_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      div_start      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cand_in        = 1'b0;
            cand_amount_in = diff[VALUE_WIDTH-2:0];
            state_in       = ST_FINISH;
            if (samp_start_ff) begin
               best_frac_in   = '0;
               best_amount_in = '0;
               best_start_in  = '0;
               best_end_in    = '0;
               peak_in        = samp_value_ff;
               peak_date_in   = samp_date_ff;
            end else if (raises_peak) begin
               peak_in      = value_clamp;
               peak_date_in = samp_date_ff;
            end else if (peak_pos) begin
               cand_in = 1'b1;
               if (diff >= VALUE_WIDTH'(peak_ff)) begin
                  cand_frac_in = FRAC_ONE;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               cand_frac_in = {1'b0, div_quot};
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (cand_ff && (cand_frac_ff > best_frac_ff)) begin
                  best_frac_in   = cand_frac_ff;
                  best_amount_in = cand_amount_ff;
                  best_start_in  = peak_date_ff;
                  best_end_in    = samp_date_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers and tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         cand_ff        <= 1'b0;
         peak_ff        <= '0;
         peak_date_ff   <= '0;
         best_frac_ff   <= '0;
         best_amount_ff <= '0;
         best_start_ff  <= '0;
         best_end_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         cand_ff        <= cand_in;
         peak_ff        <= peak_in;
         peak_date_ff   <= peak_date_in;
         best_frac_ff   <= best_frac_in;
         best_amount_ff <= best_amount_in;
         best_start_ff  <= best_start_in;
         best_end_ff    <= best_end_in;
      end
   end

   // capture the sample beat, hold the candidate, load the result slot
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         samp_value_ff <= req_chan.value;
         samp_date_ff  <= req_chan.date_code;
         samp_start_ff <= req_chan.curve_start;
      end
      cand_frac_ff   <= cand_frac_in;
      cand_amount_ff <= cand_amount_in;
      if ((state_ff == ST_FINISH) && slot_free) begin
         rsp_frac_ff   <= best_frac_in;
         rsp_amount_ff <= best_amount_in;
         rsp_start_ff  <= best_start_in;
         rsp_end_ff    <= best_end_in;
      end
   end

   mdt_serial_div #(
      .VALUE_WIDTH   (VALUE_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (diff),
      .den    (VALUE_WIDTH'(peak_ff)),
      .status (div_stat),
      .quot   (div_quot)
   );

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.drawdown_frac = rsp_frac_ff;
   assign rsp_chan.loss_amount   = rsp_amount_ff;
   assign rsp_chan.peak_code     = rsp_start_ff;
   assign rsp_chan.trough_code   = rsp_end_ff;

   // best fraction never exceeds 1.0
   a_frac_cap: assert property (@(posedge clock) disable iff (reset)
      best_frac_ff <= FRAC_ONE)
      else $error("best drawdown above 1.0");

   // finishing a sample never lowers the best fraction
   a_best_monotonic: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |=> (best_frac_ff >= $past(best_frac_ff)))
      else $error("best drawdown decreased on update");

   // an accepted beat always moves the sequencer to evaluation
   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == ST_EVAL))
      else $error("accepted beat not evaluated");

   // the divider runs only while the sequencer waits on it
   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == ST_DIV))
      else $error("divider busy outside divide state");

endmodule
